FILE: src/sva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_pkg - shared types for the synth voice allocator
// Command and result transaction structs, sequencer states and event codes.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int CHAN_W = 4;
  localparam int KEY_W  = 7;
  localparam int VEL_W  = 7;
  localparam int IDX_W  = 4;

  // event codes
  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CHAN_W-1:0] channel;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  voice_index;
    logic              voice_found;
    logic              was_reused;
    logic              stole_held_note;
    logic [CHAN_W-1:0] out_channel;
    logic [KEY_W-1:0]  out_key;
    logic [VEL_W-1:0]  out_velocity;
    logic              gate_now;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

FILE: src/synth_voice_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synth_voice_allocator - polyphonic voice allocator with oldest-voice stealing
// Tracks owner channel, key, gate and stamp per voice, serves note on / off.
// ----------------------------------------------------------------------------
// usage
//   command channel: a transaction is taken at a rising edge with start high
//   and busy low; cmd carries operation, channel, key and velocity
//   result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall, so it must sample result whenever done is high
// timing
//   a valid event scans the voice table one voice per cycle through a single
//   subtract-and-compare unit fed by the registered table read port
//   busy stays high for VOICE_COUNT + 2 cycles (scan plus final write)
//   done rises VOICE_COUNT + 2 cycles after the accepting edge, and a new
//   event can be taken in that same cycle: one event per VOICE_COUNT + 3 cycles
//   an event on a channel at or above CHANNEL_COUNT is dropped: an all-zero
//   result follows one cycle later, busy never rises
// reset
//   synchronous rst frees every voice (assigned and gate bits clear), zeroes
//   the event counter and returns the sequencer to idle; free voices read
//   back a zero stamp, so the table memory itself needs no clearing pass
// ----------------------------------------------------------------------------
module synth_voice_allocator #(
  parameter int VOICE_COUNT   = 16,
  parameter int CHANNEL_COUNT = 16,
  parameter int STAMP_BITS    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sva_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output sva_pkg::result_t result
);

  import sva_pkg::*;

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CW = $clog2(VOICE_COUNT + 1);

  // sequencer
  state_t state;
  state_t state_next;

  // latched command
  cmd_t cur;

  // per-voice flags in flip-flops, reset at once
  logic [VOICE_COUNT-1:0] assigned;
  logic [VOICE_COUNT-1:0] gate;

  // voice table memory, read one entry per cycle
  logic [CHAN_W-1:0]     mem_chan  [VOICE_COUNT];
  logic [KEY_W-1:0]      mem_key   [VOICE_COUNT];
  logic [STAMP_BITS-1:0] mem_stamp [VOICE_COUNT];

  logic [CHAN_W-1:0]     rd_chan;
  logic [KEY_W-1:0]      rd_key;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic [VW-1:0]         rd_idx;
  logic                  rd_vld;

  logic [CW-1:0]         cnt;
  logic [VW-1:0]         rd_addr;
  logic                  issue;

  logic [STAMP_BITS-1:0] counter;

  // scan results
  logic                  found;
  logic [VW-1:0]         match_idx;
  logic [VW-1:0]         best_idx;
  logic [STAMP_BITS-1:0] best_age;
  logic                  best_held;

  // shared compare unit
  logic                  e_assigned;
  logic                  e_gate;
  logic [STAMP_BITS-1:0] e_stamp;
  logic [STAMP_BITS-1:0] e_age;
  logic                  e_older;
  logic                  e_match;

  // finish stage
  logic                  ch_ok;
  logic [VW-1:0]         sel;
  logic                  wr_on;
  logic                  wr_off;
  result_t               result_next;

  assign ch_ok   = (5'(cmd.channel) < 5'(CHANNEL_COUNT));
  assign rd_addr = cnt[VW-1:0];
  assign issue   = (state == ST_SCAN) && (cnt < CW'(VOICE_COUNT));

  assign e_assigned = assigned[rd_idx];
  assign e_gate     = gate[rd_idx];
  // a free voice carries the reset stamp
  assign e_stamp    = e_assigned ? rd_stamp : '0;
  assign e_age      = counter - e_stamp;
  assign e_older    = (e_age >= best_age);
  assign e_match    = e_assigned && (rd_chan == cur.channel) && (rd_key == cur.key);

  assign sel    = found ? match_idx : best_idx;
  assign wr_on  = (state == ST_FINISH) && (cur.operation == OP_NOTE_ON);
  assign wr_off = (state == ST_FINISH) && (cur.operation == OP_NOTE_OFF) && found;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && ch_ok) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == CW'(VOICE_COUNT)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // table memory: registered read, single write
  always_ff @(posedge clk) begin
    rd_chan  <= mem_chan[rd_addr];
    rd_key   <= mem_key[rd_addr];
    rd_stamp <= mem_stamp[rd_addr];
    if (wr_on) begin
      mem_chan[sel] <= cur.channel;
      mem_key[sel]  <= cur.key;
    end
    if (wr_on || wr_off) begin
      mem_stamp[sel] <= counter;
    end
  end

  // latched command and per-entry scan state
  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    if (state == ST_IDLE && start) begin
      cur <= cmd;
    end
    if (rd_vld) begin
      if (e_match && !found) begin
        match_idx <= rd_idx;
      end
      // first entry seeds the steal choice, later index wins on equal age
      if (rd_idx == '0) begin
        best_idx  <= rd_idx;
        best_age  <= e_age;
        best_held <= e_gate;
      end else if (e_gate) begin
        if (best_held && e_older) begin
          best_idx <= rd_idx;
          best_age <= e_age;
        end
      end else if (best_held || e_older) begin
        best_held <= 1'b0;
        best_idx  <= rd_idx;
        best_age  <= e_age;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      assigned <= '0;
      gate     <= '0;
      counter  <= '0;
      cnt      <= '0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
      done     <= 1'b0;
    end else begin
      // out-of-range channel: empty result, the sequencer stays idle
      done   <= (state == ST_FINISH) || (state == ST_IDLE && start && !ch_ok);
      rd_vld <= issue;
      case (state)
        ST_IDLE: begin
          cnt   <= '0;
          found <= 1'b0;
        end
        ST_SCAN: begin
          if (issue) begin
            cnt <= cnt + CW'(1);
          end
          if (rd_vld && e_match) begin
            found <= 1'b1;
          end
        end
        ST_FINISH: begin
          if (wr_on) begin
            assigned[sel] <= 1'b1;
            gate[sel]     <= 1'b1;
            counter       <= counter + STAMP_BITS'(1);
          end else if (wr_off) begin
            gate[sel] <= 1'b0;
            counter   <= counter + STAMP_BITS'(1);
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  // result payload, all zero unless a voice is written
  always_comb begin
    result_next = '0;
    if (wr_on) begin
      result_next.voice_index     = IDX_W'(sel);
      result_next.voice_found     = 1'b1;
      result_next.was_reused      = found;
      result_next.stole_held_note = !found && best_held;
      result_next.out_channel     = cur.channel;
      result_next.out_key         = cur.key;
      result_next.out_velocity    = cur.velocity;
      result_next.gate_now        = 1'b1;
    end else if (wr_off) begin
      result_next.voice_index = IDX_W'(sel);
      result_next.voice_found = 1'b1;
      result_next.out_channel = cur.channel;
      result_next.out_key     = cur.key;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE && start && !ch_ok) || (state == ST_FINISH)) begin
      result <= result_next;
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ch_ok) |=> busy)
    else $error("valid event accepted but sequencer did not start");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && !result.voice_found) |->
      (result == '0))
    else $error("no voice found but result not empty");

  a_reuse_no_steal: assert property (@(posedge clk) disable iff (rst)
    (done && result.was_reused) |-> (!result.stole_held_note && result.gate_now))
    else $error("reused voice flagged as stolen or ungated");

endmodule
